@@ rtl/ypp_pkg.sv @@
// ypp_pkg: shared types, constants and the quarter-wave sine table builder
// for the yaw/pitch pose integrator. No dependencies.

package ypp_pkg;

    // default quarter-wave table depth, must be a power of two (64 to 4096)
    localparam int SINE_DEPTH_DEF = 256;

    localparam int TWO_PI_Q12    = 25736;
    localparam int HALF_TURN_Q12 = TWO_PI_Q12 / 2;

    localparam int DELTA_W = 24;
    localparam int POS_W   = 32;
    localparam int PITCH_W = 14;
    localparam int YAW_W   = 15;
    localparam int TRIG_W  = 16;
    localparam int ROM_W   = 15;
    localparam int CFG_W   = 14;
    localparam int PMAX_W  = 13;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 176;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic signed [PITCH_W-1:0] PITCH_MIN_RST = -14'sd5615;
    localparam logic [PMAX_W-1:0]         PITCH_MAX_RST = 13'd5615;
    localparam logic signed [POS_W-1:0]   POS_Z_RST     = -32'sd196608;

    // divisors (2k)(2k+1) of the taylor terms, k = 1..8
    localparam logic [63:0] TAYLOR_DIV [8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    typedef enum logic [0:0] {
        CFG_PITCH_MIN = 1'b0,
        CFG_PITCH_MAX = 1'b1
    } cfg_idx_t;

    typedef enum logic [0:0] {
        CMD_MOVE   = 1'b0,
        CMD_ROTATE = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t                       cmd;
        logic signed [DELTA_W-1:0]  d_x;
        logic signed [DELTA_W-1:0]  d_y;
        logic signed [DELTA_W-1:0]  d_z;
    } item_t;

    typedef struct packed {
        logic signed [POS_W-1:0]    pos_x;
        logic signed [POS_W-1:0]    pos_y;
        logic signed [POS_W-1:0]    pos_z;
        logic signed [PITCH_W-1:0]  pitch;
        logic [YAW_W-1:0]           yaw;
        logic signed [TRIG_W-1:0]   sin_pitch;
        logic signed [TRIG_W-1:0]   cos_pitch;
        logic signed [TRIG_W-1:0]   sin_yaw;
        logic signed [TRIG_W-1:0]   cos_yaw;
    } pose_t;

    // sine of x (Q2.30 radians) in Q1.14, taylor series up to x^17
    function automatic logic [ROM_W-1:0] sine_entry(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        logic [63:0]        rnd;
        x2   = (x * x) >> 30;
        term = x;
        acc  = $signed(x);
        for (int k = 0; k < 8; k++) begin
            term = (term * x2) >> 30;
            term = term / TAYLOR_DIV[k];
            if (k[0] == 1'b0) begin
                acc = acc - $signed(term);
            end else begin
                acc = acc + $signed(term);
            end
        end
        if (acc < 0) begin
            acc = '0;
        end
        rnd = (64'(acc) + 64'd32768) >> 16;
        return rnd[ROM_W-1:0];
    endfunction

    // cosine of a zero angle, reset value of the cached cosine terms
    localparam logic [ROM_W-1:0] COS_ZERO = sine_entry(HALF_PI_Q30);

endpackage

@@ rtl/ypp_trig.sv @@
// ypp_trig: sine and cosine of a Q4.12 angle in Q1.14 through a quarter-wave
// constant table; phase found by reciprocal multiply. Depends on ypp_pkg.

module ypp_trig #(
    parameter int SINE_TABLE_DEPTH = ypp_pkg::SINE_DEPTH_DEF
) (
    input  logic signed [15:0]                 angle,
    output logic signed [ypp_pkg::TRIG_W-1:0]  sin_q14,
    output logic signed [ypp_pkg::TRIG_W-1:0]  cos_q14
);

    localparam int LOG2D   = $clog2(SINE_TABLE_DEPTH);
    localparam int PH_W    = LOG2D + 2;
    localparam int IDX_W   = LOG2D + 1;
    localparam int NUM_W   = 15 + PH_W;
    localparam int SHIFT   = NUM_W + 15;
    localparam int RECIP_W = SHIFT - 14;
    localparam int PROD_W  = NUM_W + RECIP_W;
    localparam logic [63:0] RECIP =
        ((64'd1 << SHIFT) + 64'(ypp_pkg::TWO_PI_Q12 - 1)) / 64'(ypp_pkg::TWO_PI_Q12);
    localparam logic signed [15:0] TWO_PI_S = 16'(ypp_pkg::TWO_PI_Q12);

    logic [ypp_pkg::ROM_W-1:0] rom [SINE_TABLE_DEPTH+1];

    for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_rom
        localparam logic [63:0] X_Q30 =
            (ypp_pkg::HALF_PI_Q30 * 64'(gi)) / 64'(SINE_TABLE_DEPTH);
        assign rom[gi] = ypp_pkg::sine_entry(X_Q30);
    end

    logic signed [15:0]    m_s;
    logic [14:0]           m;
    logic [NUM_W-1:0]      num;
    logic [PROD_W-1:0]     prod;
    logic [PH_W:0]         q;
    logic [PH_W-1:0]       ph_sin;
    logic [PH_W-1:0]       ph_cos;
    logic [IDX_W-1:0]      idx_sin;
    logic [IDX_W-1:0]      idx_cos;
    logic [ypp_pkg::ROM_W-1:0] val_sin;
    logic [ypp_pkg::ROM_W-1:0] val_cos;

    // angle into 0 .. 2*pi - 1 lsb by one add or subtract of 2*pi (inputs from -2*pi up)
    always_comb begin
        if (angle < 16'sd0) begin
            m_s = angle + TWO_PI_S;
        end else if (angle >= TWO_PI_S) begin
            m_s = angle - TWO_PI_S;
        end else begin
            m_s = angle;
        end
        m = m_s[14:0];
    end

    // phase = round(m * 4D / 2pi), exact by reciprocal
    assign num    = (NUM_W'(m) << PH_W) + NUM_W'(ypp_pkg::HALF_TURN_Q12);
    assign prod   = PROD_W'(num) * PROD_W'(RECIP[RECIP_W-1:0]);
    assign q      = prod[SHIFT +: PH_W+1];
    assign ph_sin = q[PH_W] ? '0 : q[PH_W-1:0];
    assign ph_cos = ph_sin + PH_W'(SINE_TABLE_DEPTH);

    always_comb begin
        idx_sin = ph_sin[PH_W-2] ? IDX_W'(SINE_TABLE_DEPTH) - IDX_W'(ph_sin[LOG2D-1:0])
                                 : IDX_W'(ph_sin[LOG2D-1:0]);
        idx_cos = ph_cos[PH_W-2] ? IDX_W'(SINE_TABLE_DEPTH) - IDX_W'(ph_cos[LOG2D-1:0])
                                 : IDX_W'(ph_cos[LOG2D-1:0]);
        val_sin = rom[idx_sin];
        val_cos = rom[idx_cos];
        sin_q14 = ph_sin[PH_W-1] ? -$signed({1'b0, val_sin}) : $signed({1'b0, val_sin});
        cos_q14 = ph_cos[PH_W-1] ? -$signed({1'b0, val_cos}) : $signed({1'b0, val_cos});
    end

endmodule

@@ rtl/ypp_pose.sv @@
// ypp_pose: pose state, pitch limit registers and the per-word move/rotate
// update, with cached trig terms of the current angles. Depends on ypp_pkg, ypp_trig.

module ypp_pose #(
    parameter int SINE_TABLE_DEPTH = ypp_pkg::SINE_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [0:0]                   cfg_index,
    input  logic [ypp_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                         load,
    input  ypp_pkg::item_t               item,
    output ypp_pkg::pose_t               pose
);

    localparam logic signed [23:0] TURN24 = 24'(ypp_pkg::TWO_PI_Q12);
    localparam logic signed [16:0] TURN17 = 17'(ypp_pkg::TWO_PI_Q12);

    ypp_pkg::pose_t                        pose_reg;
    ypp_pkg::pose_t                        pose_next;
    logic signed [ypp_pkg::PITCH_W-1:0]    pitch_min_reg;
    logic [ypp_pkg::PMAX_W-1:0]            pitch_max_reg;

    logic signed [39:0] xs_prod, xc_prod, zs_prod, zc_prod;
    logic signed [40:0] mx, mz, mx_rnd, mz_rnd;
    logic signed [26:0] step_x, step_z;
    logic signed [15:0] turn_p, turn_y;
    logic signed [16:0] p_sum, y_sum, y_wrap, pmin_ext, pmax_ext, p_clamp;
    logic signed [ypp_pkg::PITCH_W-1:0] pitch_new;
    logic [ypp_pkg::YAW_W-1:0]          yaw_new;
    logic signed [ypp_pkg::POS_W-1:0]   pos_x_new, pos_y_new, pos_z_new;
    logic signed [ypp_pkg::TRIG_W-1:0]  sp, cp, sy, cy;

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [15:0] sat_turn(input logic signed [23:0] v);
        if (v > TURN24) begin
            return TURN24[15:0];
        end else if (v < -TURN24) begin
            return -(TURN24[15:0]);
        end
        return v[15:0];
    endfunction

    // move: rotate strafe/forward deltas by the cached yaw terms
    always_comb begin
        xs_prod = $signed(item.d_z) * $signed(pose_reg.sin_yaw);
        xc_prod = $signed(item.d_x) * $signed(pose_reg.cos_yaw);
        zc_prod = $signed(item.d_z) * $signed(pose_reg.cos_yaw);
        zs_prod = $signed(item.d_x) * $signed(pose_reg.sin_yaw);
        mx      = 41'(xs_prod) + 41'(xc_prod);
        mz      = 41'(zc_prod) - 41'(zs_prod);
        mx_rnd  = (mx + 41'sd8192) >>> 14;
        mz_rnd  = (mz + 41'sd8192) >>> 14;
        step_x  = mx_rnd[26:0];
        step_z  = mz_rnd[26:0];
    end

    // rotate: saturated deltas, pitch clamp, single yaw wrap
    always_comb begin
        turn_p   = sat_turn(item.d_x);
        turn_y   = sat_turn(item.d_y);
        p_sum    = 17'(pose_reg.pitch) + 17'(turn_p);
        y_sum    = $signed({2'b00, pose_reg.yaw}) + 17'(turn_y);
        pmin_ext = 17'(pitch_min_reg);
        pmax_ext = $signed({4'b0000, pitch_max_reg});
        if (y_sum < 17'sd0) begin
            y_wrap = y_sum + TURN17;
        end else if (y_sum > TURN17) begin
            y_wrap = y_sum - TURN17;
        end else begin
            y_wrap = y_sum;
        end
        priority if (p_sum < pmin_ext) begin
            p_clamp = pmin_ext;
        end else if (p_sum > pmax_ext) begin
            p_clamp = pmax_ext;
        end else begin
            p_clamp = p_sum;
        end
    end

    always_comb begin
        unique case (item.cmd)
            ypp_pkg::CMD_ROTATE: begin
                pitch_new = p_clamp[ypp_pkg::PITCH_W-1:0];
                yaw_new   = y_wrap[ypp_pkg::YAW_W-1:0];
                pos_x_new = pose_reg.pos_x;
                pos_y_new = pose_reg.pos_y;
                pos_z_new = pose_reg.pos_z;
            end
            default: begin
                pitch_new = pose_reg.pitch;
                yaw_new   = pose_reg.yaw;
                pos_x_new = sat32(33'(pose_reg.pos_x) + 33'(step_x));
                pos_y_new = sat32(33'(pose_reg.pos_y) + 33'(item.d_y));
                pos_z_new = sat32(33'(pose_reg.pos_z) + 33'(step_z));
            end
        endcase
    end

    ypp_trig #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_trig_pitch (
        .angle   (16'(pitch_new)),
        .sin_q14 (sp),
        .cos_q14 (cp)
    );

    ypp_trig #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_trig_yaw (
        .angle   ($signed({1'b0, yaw_new})),
        .sin_q14 (sy),
        .cos_q14 (cy)
    );

    always_comb begin
        pose_next           = pose_reg;
        if (load) begin
            pose_next.pos_x     = pos_x_new;
            pose_next.pos_y     = pos_y_new;
            pose_next.pos_z     = pos_z_new;
            pose_next.pitch     = pitch_new;
            pose_next.yaw       = yaw_new;
            pose_next.sin_pitch = sp;
            pose_next.cos_pitch = cp;
            pose_next.sin_yaw   = sy;
            pose_next.cos_yaw   = cy;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pose_reg.pos_x     <= '0;
            pose_reg.pos_y     <= '0;
            pose_reg.pos_z     <= ypp_pkg::POS_Z_RST;
            pose_reg.pitch     <= '0;
            pose_reg.yaw       <= '0;
            pose_reg.sin_pitch <= '0;
            pose_reg.cos_pitch <= $signed({1'b0, ypp_pkg::COS_ZERO});
            pose_reg.sin_yaw   <= '0;
            pose_reg.cos_yaw   <= $signed({1'b0, ypp_pkg::COS_ZERO});
        end else begin
            pose_reg <= pose_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_min_reg <= ypp_pkg::PITCH_MIN_RST;
            pitch_max_reg <= ypp_pkg::PITCH_MAX_RST;
        end else if (cfg_wr_en) begin
            unique case (ypp_pkg::cfg_idx_t'(cfg_index))
                ypp_pkg::CFG_PITCH_MIN: pitch_min_reg <= $signed(cfg_wdata);
                ypp_pkg::CFG_PITCH_MAX: pitch_max_reg <= cfg_wdata[ypp_pkg::PMAX_W-1:0];
                default: ;
            endcase
        end
    end

    assign pose = pose_reg;

endmodule

@@ rtl/ypp_out.sv @@
// ypp_out: result register; forms the forward vector from the cached trig
// terms and packs the result word. Depends on ypp_pkg.

module ypp_out (
    input  logic                             aclk,
    input  logic                             load,
    input  ypp_pkg::pose_t                   pose,
    output logic [ypp_pkg::M_TDATA_W-1:0]    data
);

    logic [ypp_pkg::M_TDATA_W-1:0] data_reg;
    logic [ypp_pkg::M_TDATA_W-1:0] data_next;
    logic signed [31:0] fx_prod, fz_prod;
    logic signed [32:0] fx_rnd, fz_rnd;

    always_comb begin
        fx_prod   = $signed(pose.sin_yaw) * $signed(pose.cos_pitch);
        fz_prod   = $signed(pose.cos_yaw) * $signed(pose.cos_pitch);
        fx_rnd    = 33'(fx_prod) + 33'sd8192;
        fz_rnd    = 33'(fz_prod) + 33'sd8192;
        data_next = {3'b000, fz_rnd[29:14], pose.sin_pitch, fx_rnd[29:14],
                     pose.yaw, pose.pitch, pose.pos_z, pose.pos_y, pose.pos_x};
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule

@@ rtl/yaw_pitch_pose_integrator.sv @@
// yaw_pitch_pose_integrator: top level; input register, pose update stage and
// result register with stream handshakes. Depends on ypp_pkg, ypp_pose, ypp_out.
//
//   channel   dir   payload                                     handshake
//   s_        in    tuser: cmd; tdata: d_x, d_y, d_z            tvalid/tready
//   m_        out   tdata: pos_x..z, pitch, yaw, fwd_x..z       tvalid/tready
//   cfg_      in    cfg_index 0 pitch_min, 1 pitch_max          cfg_wr_en
//
// one word per cycle sustained while m_tready is high; an accepted word passes
// the input register, pose update with trig table and result register to m_tvalid.
// the pose update loop closes through the pose register: reciprocal phase multiply + table read.
// reset is synchronous and leaves the pose at the origin with z = -3.0.
// stalls on m_tready back up through the stages; s_tready drops only when full.

module yaw_pitch_pose_integrator #(
    // quarter-wave table depth, power of two
    parameter int SINE_TABLE_DEPTH = ypp_pkg::SINE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ypp_pkg::S_TDATA_W-1:0]    s_tdata,   // d_x[23:0], d_y[47:24], d_z[71:48]
    input  logic [0:0]                       s_tuser,   // cmd[0]

    output logic                             m_tvalid,
    input  logic                             m_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64], pitch_out[109:96],
    // yaw_out[124:110], fwd_x[140:125], fwd_y[156:141], fwd_z[172:157]
    output logic [ypp_pkg::M_TDATA_W-1:0]    m_tdata,

    input  logic                             cfg_wr_en,
    input  logic [0:0]                       cfg_index,
    input  logic [ypp_pkg::CFG_W-1:0]        cfg_wdata
);

    ypp_pkg::item_t  item_reg;
    ypp_pkg::item_t  item_next;
    ypp_pkg::pose_t  pose;
    logic            in_valid_reg, in_valid_next;
    logic            pose_valid_reg, pose_valid_next;
    logic            out_valid_reg, out_valid_next;
    logic            adv_out, adv_pose, in_load;

    assign adv_out  = !out_valid_reg || m_tready;
    assign adv_pose = !pose_valid_reg || adv_out;
    assign s_tready = !in_valid_reg || adv_pose;
    assign in_load  = s_tvalid && s_tready;

    always_comb begin
        item_next.cmd = ypp_pkg::cmd_t'(s_tuser[0]);
        item_next.d_x = $signed(s_tdata[23:0]);
        item_next.d_y = $signed(s_tdata[47:24]);
        item_next.d_z = $signed(s_tdata[71:48]);

        in_valid_next   = s_tready ? s_tvalid : in_valid_reg;
        pose_valid_next = adv_pose ? in_valid_reg : pose_valid_reg;
        out_valid_next  = adv_out ? pose_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            pose_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg   <= in_valid_next;
            pose_valid_reg <= pose_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            item_reg <= item_next;
        end
    end

    ypp_pose #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_pose (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .load      (in_valid_reg && adv_pose),
        .item      (item_reg),
        .pose      (pose)
    );

    ypp_out u_out (
        .aclk (aclk),
        .load (pose_valid_reg && adv_out),
        .pose (pose),
        .data (m_tdata)
    );

    assign m_tvalid = out_valid_reg;

endmodule

@@ verif/ypp_pose_checker.sv @@
// ypp_pose_checker: watches the input, result and register ports of the pose
// integrator, predicts every result word and compares it field by field.
// Depends on ypp_pkg for widths and code names.

module ypp_pose_checker
    import ypp_pkg::*;
#(
    parameter int TABLE_DEPTH = SINE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [0:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [0:0]            cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    output int                    mismatches,
    output int                    poses_waiting,
    output int                    poses_checked
);

    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
    localparam int              PHASES           = 4 * TABLE_DEPTH;

    typedef struct packed {
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
        logic signed [POS_W-1:0]   pos_z;
        logic signed [PITCH_W-1:0] pitch;
        logic [YAW_W-1:0]          yaw;
        logic signed [TRIG_W-1:0]  fwd_x;
        logic signed [TRIG_W-1:0]  fwd_y;
        logic signed [TRIG_W-1:0]  fwd_z;
    } pose_report_t;

    int           quarter_sine [0:TABLE_DEPTH];
    pose_report_t expected_poses [$];

    int pos_x_q16;
    int pos_y_q16;
    int pos_z_q16;
    int pitch_q12;
    int yaw_q12;
    int pitch_lo;
    int pitch_hi;
    int error_count;
    int checked_count;

    // quarter-wave table: taylor series in Q2.30, rounded to Q1.14
    initial begin
        longint unsigned x, x2, term;
        longint          acc;
        for (int i = 0; i <= TABLE_DEPTH; i++) begin
            x    = (QUARTER_TURN_Q30 * i) / TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            for (int k = 1; k <= 8; k++) begin
                term = (term * x2) >> 30;
                term = term / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            quarter_sine[i] = int'((acc + 32768) >>> 16);
        end
    end

    function automatic int angle_phase(input int angle);
        int     m;
        longint p;
        m = angle % TWO_PI_Q12;
        if (m < 0) begin
            m = m + TWO_PI_Q12;
        end
        p = (longint'(m) * PHASES + TWO_PI_Q12 / 2) / TWO_PI_Q12;
        return int'(p % PHASES);
    endfunction

    function automatic int sine_at(input int phase);
        int p, r;
        p = phase % PHASES;
        r = p % TABLE_DEPTH;
        case (p / TABLE_DEPTH)
            0:       return quarter_sine[r];
            1:       return quarter_sine[TABLE_DEPTH - r];
            2:       return -quarter_sine[r];
            default: return -quarter_sine[TABLE_DEPTH - r];
        endcase
    endfunction

    function automatic int sin_q14(input int angle);
        return sine_at(angle_phase(angle));
    endfunction

    function automatic int cos_q14(input int angle);
        return sine_at(angle_phase(angle) + TABLE_DEPTH);
    endfunction

    function automatic int clamp_pos(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return int'(v);
    endfunction

    function automatic int limit_turn(input int v);
        if (v > TWO_PI_Q12) begin
            return TWO_PI_Q12;
        end
        if (v < -TWO_PI_Q12) begin
            return -TWO_PI_Q12;
        end
        return v;
    endfunction

    // applies one input word to the pose and returns the report it produces
    function automatic pose_report_t step_pose(input logic cmd_bit,
                                               input logic [S_TDATA_W-1:0] word);
        longint       dx, dy, dz, mx, mz;
        int           p, y, sy, cy, sp, cp;
        pose_report_t r;
        dx = longint'($signed(word[DELTA_W-1:0]));
        dy = longint'($signed(word[2*DELTA_W-1:DELTA_W]));
        dz = longint'($signed(word[3*DELTA_W-1:2*DELTA_W]));
        if (cmd_bit == CMD_MOVE) begin
            sy = sin_q14(yaw_q12);
            cy = cos_q14(yaw_q12);
            // strafe and forward turned by yaw, Q.30 rounded half up to Q.16
            mx = dz * sy + dx * cy;
            mz = dz * cy - dx * sy;
            pos_x_q16 = clamp_pos(longint'(pos_x_q16) + ((mx + 8192) >>> 14));
            pos_z_q16 = clamp_pos(longint'(pos_z_q16) + ((mz + 8192) >>> 14));
            pos_y_q16 = clamp_pos(longint'(pos_y_q16) + dy);
        end else begin
            p = pitch_q12 + limit_turn(int'(dx));
            y = yaw_q12 + limit_turn(int'(dy));
            if (y < 0) begin
                y = y + TWO_PI_Q12;
            end else if (y > TWO_PI_Q12) begin
                y = y - TWO_PI_Q12;
            end
            // lower limit wins when the limits cross and the sum is below it, else the upper one
            if (p < pitch_lo) begin
                p = pitch_lo;
            end else if (p > pitch_hi) begin
                p = pitch_hi;
            end
            pitch_q12 = p;
            yaw_q12   = y;
        end
        sp = sin_q14(pitch_q12);
        cp = cos_q14(pitch_q12);
        sy = sin_q14(yaw_q12);
        cy = cos_q14(yaw_q12);
        r.pos_x = pos_x_q16;
        r.pos_y = pos_y_q16;
        r.pos_z = pos_z_q16;
        r.pitch = PITCH_W'(pitch_q12);
        r.yaw   = YAW_W'(yaw_q12);
        r.fwd_x = TRIG_W'((longint'(sy) * cp + 8192) >>> 14);
        r.fwd_y = TRIG_W'(sp);
        r.fwd_z = TRIG_W'((longint'(cy) * cp + 8192) >>> 14);
        return r;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        pose_report_t got, want;
        if (!aresetn) begin
            pos_x_q16 = 0;
            pos_y_q16 = 0;
            pos_z_q16 = -196608;
            pitch_q12 = 0;
            yaw_q12   = 0;
            pitch_lo  = -5615;
            pitch_hi  = 5615;
            expected_poses.delete();
            error_count   = 0;
            checked_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.pos_x = m_tdata[31:0];
                got.pos_y = m_tdata[63:32];
                got.pos_z = m_tdata[95:64];
                got.pitch = m_tdata[109:96];
                got.yaw   = m_tdata[124:110];
                got.fwd_x = m_tdata[140:125];
                got.fwd_y = m_tdata[156:141];
                got.fwd_z = m_tdata[172:157];
                if (expected_poses.size() == 0) begin
                    $display("%0t: result word with none expected, actual %h",
                             $time, m_tdata);
                    error_count++;
                end else begin
                    want = expected_poses.pop_front();
                    check_field("pos_x", want.pos_x, got.pos_x);
                    check_field("pos_y", want.pos_y, got.pos_y);
                    check_field("pos_z", want.pos_z, got.pos_z);
                    check_field("pitch_out", want.pitch, got.pitch);
                    check_field("yaw_out", want.yaw, got.yaw);
                    check_field("fwd_x", want.fwd_x, got.fwd_x);
                    check_field("fwd_y", want.fwd_y, got.fwd_y);
                    check_field("fwd_z", want.fwd_z, got.fwd_z);
                    checked_count++;
                end
            end
            if (cfg_wr_en) begin
                if (cfg_index == CFG_PITCH_MIN) begin
                    pitch_lo = int'($signed(cfg_wdata));
                end else begin
                    pitch_hi = int'(cfg_wdata[PMAX_W-1:0]);
                end
            end
            if (s_tvalid && s_tready) begin
                expected_poses.push_back(step_pose(s_tuser[0], s_tdata));
            end
        end
        mismatches    <= error_count;
        poses_waiting <= expected_poses.size();
        poses_checked <= checked_count;
    end

endmodule

@@ verif/tb_yaw_pitch_pose_integrator.sv @@
// tb_yaw_pitch_pose_integrator: stimulus and verdict for the pose integrator;
// directed words, random and saturating sweeps under several pitch limits.
// Depends on ypp_pkg, yaw_pitch_pose_integrator and ypp_pose_checker.

module tb_yaw_pitch_pose_integrator;
    import ypp_pkg::*;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [0:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wr_en;
    logic [0:0]           cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    int mismatches;
    int poses_waiting;
    int poses_checked;

    int gap_max   = 5;
    int stall_max = 5;
    int move_count;
    int rotate_count;

    localparam logic signed [DELTA_W-1:0] D_MAX = 24'sh7FFFFF;
    localparam logic signed [DELTA_W-1:0] D_MIN = 24'sh800000;

    yaw_pitch_pose_integrator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    ypp_pose_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .poses_waiting (poses_waiting),
        .poses_checked (poses_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1000000;
        $display("TEST FAILED");
        $finish;
    end

    // result side: random stall before each word
    initial begin
        int stall;
        m_tready = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = $urandom_range(stall_max, 0);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_word(input cmd_t cmd, input logic signed [DELTA_W-1:0] dx,
                             input logic signed [DELTA_W-1:0] dy,
                             input logic signed [DELTA_W-1:0] dz);
        int gap;
        gap = $urandom_range(gap_max, 0);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {dz, dy, dx};
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_MOVE) begin
            move_count++;
        end else begin
            rotate_count++;
        end
    endtask

    // sender holds off until every result word is back
    task automatic drain_poses();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (poses_waiting != 0) @(posedge aclk);
    endtask

    task automatic set_pitch_limits(input int lo, input int hi);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_PITCH_MIN;
        cfg_wdata <= CFG_W'(lo);
        @(posedge aclk);
        cfg_index <= CFG_PITCH_MAX;
        cfg_wdata <= CFG_W'(hi);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic pick_idle_profile();
        case ($urandom_range(3, 0))
            0: begin gap_max = 5; stall_max = 5; end
            1: begin gap_max = 0; stall_max = 0; end
            2: begin gap_max = 0; stall_max = 5; end
            default: begin gap_max = 5; stall_max = 0; end
        endcase
    endtask

    function automatic logic [DELTA_W-1:0] random_delta();
        case ($urandom_range(5, 0))
            0: return D_MAX;
            1: return D_MIN;
            2: return DELTA_W'(int'($urandom_range(512, 0)) - 256);
            // around the rotation saturation point
            3: return DELTA_W'(int'($urandom_range(60000, 0)) - 30000);
            default: return DELTA_W'($urandom());
        endcase
    endfunction

    task automatic run_mixed(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                pick_idle_profile();
            end
            if ($urandom_range(1, 0) == 1) begin
                send_word(CMD_ROTATE, random_delta(), random_delta(), random_delta());
            end else begin
                send_word(CMD_MOVE, random_delta(), random_delta(), random_delta());
            end
        end
    endtask

    // large same-sign moves drive the position into saturation
    task automatic run_sweep(input int count, input bit negative);
        int a, b, c, yd;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                pick_idle_profile();
            end
            if ($urandom_range(99, 0) < 8) begin
                yd = int'($urandom_range(128, 0)) - 64;
                send_word(CMD_ROTATE, random_delta(), DELTA_W'(yd), random_delta());
            end else begin
                a = $urandom_range(8388607, 7500000);
                b = $urandom_range(8388607, 7500000);
                c = $urandom_range(8388607, 7500000);
                if (negative) begin
                    a = -a;
                    b = -b;
                    c = -c;
                end
                send_word(CMD_MOVE, DELTA_W'(a), DELTA_W'(b), DELTA_W'(c));
            end
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = CMD_MOVE;
        cfg_wr_en    = 1'b0;
        cfg_index    = CFG_PITCH_MIN;
        cfg_wdata    = '0;
        move_count   = 0;
        rotate_count = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed words under the reset pitch limits
        send_word(CMD_MOVE, 24'sd0, 24'sd0, 24'sd0);
        send_word(CMD_MOVE, D_MAX, D_MAX, D_MAX);
        send_word(CMD_MOVE, D_MIN, D_MIN, D_MIN);
        send_word(CMD_MOVE, 24'sd1, -24'sd1, -24'sd1);
        send_word(CMD_ROTATE, 24'sd0, 24'sd6434, 24'sd0);
        send_word(CMD_MOVE, D_MIN, 24'sd12345, D_MAX);
        // delta saturation, pitch clamp at both limits, d_z ignored
        send_word(CMD_ROTATE, D_MAX, D_MAX, D_MAX);
        send_word(CMD_ROTATE, D_MIN, D_MIN, D_MIN);
        // yaw exactly a full turn is kept, then wraps both ways
        send_word(CMD_ROTATE, 24'sd0, 24'sd19302, 24'sd0);
        send_word(CMD_MOVE, D_MAX, 24'sd0, D_MAX);
        send_word(CMD_ROTATE, 24'sd0, 24'sd1, 24'sd0);
        send_word(CMD_ROTATE, 24'sd0, -24'sd1, 24'sd0);
        send_word(CMD_ROTATE, 24'sd0, -24'sd1, 24'sd0);
        send_word(CMD_ROTATE, -24'sd1, 24'sd0, 24'sd0);
        send_word(CMD_ROTATE, 24'sd11230, 24'sd0, 24'sd0);
        send_word(CMD_ROTATE, 24'sd1, 24'sd0, 24'sd0);
        send_word(CMD_ROTATE, 24'sd25737, -24'sd25737, D_MIN);
        send_word(CMD_ROTATE, -24'sd25737, 24'sd25737, 24'sd0);
        send_word(CMD_ROTATE, 24'sd5615, 24'sd3217, 24'sd0);
        send_word(CMD_MOVE, -24'sd1, 24'sd1, 24'sd1);
        send_word(CMD_MOVE, 24'sd65536, -24'sd65536, 24'sd32768);
        send_word(CMD_ROTATE, 24'sd0, 24'sd12868, 24'sd0);
        send_word(CMD_MOVE, 24'sd0, 24'sd0, D_MAX);

        run_mixed(200);

        drain_poses();
        set_pitch_limits(-6434, 6434);
        run_sweep(360, 1'b0);

        drain_poses();
        set_pitch_limits(0, 0);
        run_sweep(640, 1'b1);

        // crossed limits: lower one wins for sums below it, upper one otherwise
        drain_poses();
        set_pitch_limits(3000, 1000);
        run_mixed(50);

        drain_poses();
        set_pitch_limits(-8192, 8191);
        run_mixed(50);

        drain_poses();
        repeat (8) @(posedge aclk);
        $display("sent %0d move and %0d rotate words over five pitch limit settings,",
                 move_count, rotate_count);
        $display("%0d result words compared, position driven into saturation both ways",
                 poses_checked);
        if (mismatches == 0 && poses_waiting == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
